### rtl/core/ccpt_pkg.sv
`timescale 1ns / 1ps
// shared widths, pipeline types and divider step for the circumcircle test
package ccpt_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 8;
   localparam int DIF_W      = COORD_BITS + 1;
   localparam int SQ_W       = 2 * COORD_BITS + 1;
   localparam int DTERM_W    = COORD_BITS + DIF_W;
   localparam int DET_W      = DTERM_W + 3;
   localparam int CTERM_W    = SQ_W + DIF_W;
   localparam int CEN_W      = CTERM_W + 2;
   localparam int E_W        = CEN_W + DIF_W + 3;
   localparam int NUM_W      = CEN_W + FRAC_BITS;
   localparam int DEN_W      = DET_W;
   localparam int QW         = 32;
   localparam int HI_W       = NUM_W - QW;

   typedef struct packed {
      logic             in_circle;
      logic             degen;
   } ccpt_tag_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QW-1:0]    rest;
      logic [QW-1:0]    quo;
      logic             sat;
      logic             neg;
   } ccpt_lane_type;

   typedef struct packed {
      ccpt_lane_type    lx;
      ccpt_lane_type    ly;
      logic [DEN_W-1:0] den;
      ccpt_tag_type     tag;
   } ccpt_div_type;

   function automatic ccpt_lane_type div_step(ccpt_lane_type s, logic [DEN_W-1:0] d);
      ccpt_lane_type r;
      logic [DEN_W:0] t;
      logic [DEN_W:0] diff;
      r    = s;
      t    = {s.rem, s.rest[QW-1]};
      diff = t - {1'b0, d};
      r.rest = {s.rest[QW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
         r.rem = diff[DEN_W-1:0];
         r.quo = {s.quo[QW-2:0], 1'b1};
      end else begin
         r.rem = t[DEN_W-1:0];
         r.quo = {s.quo[QW-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [QW-1:0] lane_result(ccpt_lane_type s, logic degen);
      logic [QW-1:0] r;
      if (degen) begin
         r = '0;
      end else if (s.neg) begin
         if (s.sat || s.quo > {1'b1, {(QW-1){1'b0}}}) r = {1'b1, {(QW-1){1'b0}}};
         else r = QW'(~s.quo + 1'b1);
      end else begin
         if (s.sat || s.quo[QW-1]) r = {1'b0, {(QW-1){1'b1}}};
         else r = s.quo;
      end
      return r;
   endfunction

endpackage

### rtl/core/circumcircle_point_test.sv
`timescale 1ns / 1ps
// circumcenter and incircle test of one triangle and probe point per item
//
//  channel | ports                         | handshake
//  --------+-------------------------------+---------------------------
//  request | req_a_x .. req_probe_y        | start high, busy low
//  result  | rsp_center_x .. rsp_degenerate| rsp_valid, one cycle
//
// one item per cycle
// pipeline: five arithmetic stages, divider load, 32 divider stages, output
// busy stays low; the pipeline never stalls and every item gives one result
// synchronous reset clears only the valid bits
module circumcircle_point_test
   import ccpt_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic signed [COORD_BITS-1:0] req_c_x,
   input  logic signed [COORD_BITS-1:0] req_c_y,
   input  logic signed [COORD_BITS-1:0] req_probe_x,
   input  logic signed [COORD_BITS-1:0] req_probe_y,
   output logic                         rsp_valid,
   output logic signed [QW-1:0]         rsp_center_x,
   output logic signed [QW-1:0]         rsp_center_y,
   output logic                         rsp_inside_res,
   output logic                         rsp_degenerate
);

   logic [4:0] v_ff;

   // stage 1: squares and differences
   logic signed [COORD_BITS-1:0] ax_ff, bx_ff, cx_ff;
   logic signed [SQ_W-1:0]       sa_ff, sb_ff, sc_ff, sp_ff;
   logic signed [DIF_W-1:0]      byc_ff, cya_ff, aby_ff, cxb_ff, axc_ff, bxa_ff;
   logic signed [DIF_W-1:0]      pxa_ff, pya_ff;

   // stage 2: products
   logic signed [DTERM_W-1:0]    d1_ff, d2_ff, d3_ff;
   logic signed [CTERM_W-1:0]    x1_ff, x2_ff, x3_ff, y1_ff, y2_ff, y3_ff;
   logic signed [SQ_W-1:0]       spa_ff;
   logic signed [DIF_W-1:0]      pxa2_ff, pya2_ff;

   // stage 3: sums
   logic signed [DET_W-1:0]      det_ff;
   logic signed [CEN_W-1:0]      xc_ff, yc_ff;
   logic signed [SQ_W-1:0]       spa3_ff;
   logic signed [DIF_W-1:0]      pxa3_ff, pya3_ff;

   // stage 4: incircle products and magnitudes
   logic signed [E_W-1:0]        e1_ff, e2_ff, e3_ff;
   logic [NUM_W-1:0]             nx_ff, ny_ff;
   logic                         negx_ff, negy_ff, detneg_ff, degen_ff;
   logic [DEN_W-1:0]             den_ff;

   // stage 5: incircle sign
   logic [NUM_W-1:0]             nx5_ff, ny5_ff;
   logic                         negx5_ff, negy5_ff;
   logic [DEN_W-1:0]             den5_ff;
   ccpt_tag_type                 tag5_ff;

   logic [CEN_W-1:0]             xmag, ymag;
   logic [DET_W-1:0]             dmag;
   logic signed [E_W-1:0]        e_sum;
   ccpt_tag_type                 tag5_in;

   ccpt_tag_type                 out_tag;

   assign busy = 1'b0;

   assign xmag = xc_ff[CEN_W-1] ? CEN_W'(-xc_ff) : xc_ff;
   assign ymag = yc_ff[CEN_W-1] ? CEN_W'(-yc_ff) : yc_ff;
   assign dmag = det_ff[DET_W-1] ? DET_W'(-det_ff) : det_ff;

   always_comb begin
      e_sum             = e1_ff - e2_ff - e3_ff;
      tag5_in.degen     = degen_ff;
      tag5_in.in_circle = !degen_ff &&
                          ((e_sum == '0) || (detneg_ff ? (e_sum > 0) : (e_sum < 0)));
   end

   always_ff @(posedge clock) begin
      ax_ff  <= req_a_x;
      bx_ff  <= req_b_x;
      cx_ff  <= req_c_x;
      sa_ff  <= req_a_x * req_a_x + req_a_y * req_a_y;
      sb_ff  <= req_b_x * req_b_x + req_b_y * req_b_y;
      sc_ff  <= req_c_x * req_c_x + req_c_y * req_c_y;
      sp_ff  <= req_probe_x * req_probe_x + req_probe_y * req_probe_y;
      byc_ff <= req_b_y - req_c_y;
      cya_ff <= req_c_y - req_a_y;
      aby_ff <= req_a_y - req_b_y;
      cxb_ff <= req_c_x - req_b_x;
      axc_ff <= req_a_x - req_c_x;
      bxa_ff <= req_b_x - req_a_x;
      pxa_ff <= req_probe_x - req_a_x;
      pya_ff <= req_probe_y - req_a_y;

      d1_ff   <= ax_ff * byc_ff;
      d2_ff   <= bx_ff * cya_ff;
      d3_ff   <= cx_ff * aby_ff;
      x1_ff   <= sa_ff * byc_ff;
      x2_ff   <= sb_ff * cya_ff;
      x3_ff   <= sc_ff * aby_ff;
      y1_ff   <= sa_ff * cxb_ff;
      y2_ff   <= sb_ff * axc_ff;
      y3_ff   <= sc_ff * bxa_ff;
      spa_ff  <= sp_ff - sa_ff;
      pxa2_ff <= pxa_ff;
      pya2_ff <= pya_ff;

      det_ff  <= d1_ff + d2_ff + d3_ff;
      xc_ff   <= x1_ff + x2_ff + x3_ff;
      yc_ff   <= y1_ff + y2_ff + y3_ff;
      spa3_ff <= spa_ff;
      pxa3_ff <= pxa2_ff;
      pya3_ff <= pya2_ff;

      e1_ff     <= det_ff * spa3_ff;
      e2_ff     <= xc_ff * pxa3_ff;
      e3_ff     <= yc_ff * pya3_ff;
      nx_ff     <= {xmag, {FRAC_BITS{1'b0}}};
      ny_ff     <= {ymag, {FRAC_BITS{1'b0}}};
      negx_ff   <= xc_ff[CEN_W-1] ^ det_ff[DET_W-1];
      negy_ff   <= yc_ff[CEN_W-1] ^ det_ff[DET_W-1];
      detneg_ff <= det_ff[DET_W-1];
      degen_ff  <= (det_ff == '0);
      den_ff    <= {dmag[DET_W-2:0], 1'b0};

      nx5_ff   <= nx_ff;
      ny5_ff   <= ny_ff;
      negx5_ff <= negx_ff;
      negy5_ff <= negy_ff;
      den5_ff  <= den_ff;
      tag5_ff  <= tag5_in;

      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[3:0], start};
      end
   end

   ccpt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v_ff[4]),
      .num_x     (nx5_ff),
      .num_y     (ny5_ff),
      .neg_x     (negx5_ff),
      .neg_y     (negy5_ff),
      .den       (den5_ff),
      .tag       (tag5_ff),
      .out_valid (rsp_valid),
      .quo_x     (rsp_center_x),
      .quo_y     (rsp_center_y),
      .out_tag   (out_tag)
   );

   assign rsp_inside_res = out_tag.in_circle;
   assign rsp_degenerate = out_tag.degen;

endmodule

### rtl/core/ccpt_div.sv
`timescale 1ns / 1ps
// two-lane pipelined restoring divider, one quotient bit per stage
module ccpt_div
   import ccpt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [NUM_W-1:0]    num_x,
   input  logic [NUM_W-1:0]    num_y,
   input  logic                neg_x,
   input  logic                neg_y,
   input  logic [DEN_W-1:0]    den,
   input  ccpt_tag_type        tag,
   output logic                out_valid,
   output logic [QW-1:0]       quo_x,
   output logic [QW-1:0]       quo_y,
   output ccpt_tag_type        out_tag
);

   ccpt_div_type     st_ff [0:QW];
   logic [QW:0]      vld_ff;
   ccpt_div_type     ld_in;
   logic             out_valid_ff;
   logic [QW-1:0]    quo_x_ff;
   logic [QW-1:0]    quo_y_ff;
   ccpt_tag_type     tag_ff;

   always_comb begin
      ld_in.den     = den;
      ld_in.tag     = tag;
      ld_in.lx.rem  = DEN_W'(num_x[NUM_W-1:QW]);
      ld_in.lx.rest = num_x[QW-1:0];
      ld_in.lx.quo  = '0;
      ld_in.lx.sat  = DEN_W'(num_x[NUM_W-1:QW]) >= den;
      ld_in.lx.neg  = neg_x;
      ld_in.ly.rem  = DEN_W'(num_y[NUM_W-1:QW]);
      ld_in.ly.rest = num_y[QW-1:0];
      ld_in.ly.quo  = '0;
      ld_in.ly.sat  = DEN_W'(num_y[NUM_W-1:QW]) >= den;
      ld_in.ly.neg  = neg_y;
   end

   always_ff @(posedge clock) begin
      st_ff[0] <= ld_in;
      for (int k = 0; k < QW; k++) begin
         st_ff[k+1].lx  <= div_step(st_ff[k].lx, st_ff[k].den);
         st_ff[k+1].ly  <= div_step(st_ff[k].ly, st_ff[k].den);
         st_ff[k+1].den <= st_ff[k].den;
         st_ff[k+1].tag <= st_ff[k].tag;
      end
      quo_x_ff <= lane_result(st_ff[QW].lx, st_ff[QW].tag.degen);
      quo_y_ff <= lane_result(st_ff[QW].ly, st_ff[QW].tag.degen);
      tag_ff   <= st_ff[QW].tag;
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[QW-1:0], in_valid};
         out_valid_ff <= vld_ff[QW];
      end
   end

   assign out_valid = out_valid_ff;
   assign quo_x     = quo_x_ff;
   assign quo_y     = quo_y_ff;
   assign out_tag   = tag_ff;

endmodule

### tb/circumcircle_point_test_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the circumcircle point test block
module circumcircle_point_test_tb;
   import ccpt_pkg::*;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type ax, ay, bx, by, cx, cy, px, py;
   } tri_item_type;

   typedef struct {
      logic signed [QW-1:0] center_x;
      logic signed [QW-1:0] center_y;
      logic                 in_circle;
      logic                 degen;
   } circle_res_type;

   localparam longint RES_MAX = (longint'(1) << 31) - 1;
   localparam longint RES_MIN = -(longint'(1) << 31);

   logic   clock;
   logic   reset;
   logic   start;
   logic   busy;
   coord_type req_a_x, req_a_y, req_b_x, req_b_y;
   coord_type req_c_x, req_c_y, req_probe_x, req_probe_y;
   logic   rsp_valid;
   logic signed [QW-1:0] rsp_center_x, rsp_center_y;
   logic   rsp_inside_res, rsp_degenerate;

   tri_item_type   pending_items[$];
   circle_res_type expected_circles[$];
   logic        took;
   int          items_sent;
   int          errors;

   circumcircle_point_test u_top (
      .clock, .reset, .start, .busy,
      .req_a_x, .req_a_y, .req_b_x, .req_b_y, .req_c_x, .req_c_y,
      .req_probe_x, .req_probe_y,
      .rsp_valid, .rsp_center_x, .rsp_center_y, .rsp_inside_res, .rsp_degenerate
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic longint scaled_quotient(longint num, longint den);
      longint q, r, v, scale;
      scale = longint'(1) << FRAC_BITS;
      q = num / den;
      r = num % den;
      if (q >= (longint'(1) << 31)) return RES_MAX;
      if (q <= -(longint'(1) << 31)) return RES_MIN;
      v = q * scale + (r * scale) / den;
      if (v > RES_MAX) return RES_MAX;
      if (v < RES_MIN) return RES_MIN;
      return v;
   endfunction

   function automatic circle_res_type circumcircle_of(tri_item_type t);
      circle_res_type res;
      longint ax, ay, bx, by, cx, cy, px, py, sa, sp, sb, sc, det, xc, yc;
      logic signed [127:0] e;
      ax = t.ax; ay = t.ay; bx = t.bx; by = t.by;
      cx = t.cx; cy = t.cy; px = t.px; py = t.py;
      sa = ax * ax + ay * ay;
      sb = bx * bx + by * by;
      sc = cx * cx + cy * cy;
      sp = px * px + py * py;
      det = ax * by + bx * cy + cx * ay - ax * cy - bx * ay - cx * by;
      xc = sa * (by - cy) + sb * (cy - ay) + sc * (ay - by);
      yc = sa * (cx - bx) + sb * (ax - cx) + sc * (bx - ax);
      if (det == 0) begin
         res.center_x = '0;
         res.center_y = '0;
         res.in_circle = 1'b0;
         res.degen = 1'b1;
         return res;
      end
      res.center_x = QW'(scaled_quotient(xc, 2 * det));
      res.center_y = QW'(scaled_quotient(yc, 2 * det));
      e = 128'(signed'(det)) * 128'(signed'(sp - sa))
          - 128'(signed'(xc)) * 128'(signed'(px - ax))
          - 128'(signed'(yc)) * 128'(signed'(py - ay));
      if (e == 0) res.in_circle = 1'b1;
      else if (det > 0) res.in_circle = e < 0;
      else res.in_circle = e > 0;
      res.degen = 1'b0;
      return res;
   endfunction

   function automatic coord_type rand_coord(int span);
      return coord_type'($urandom_range(2 * span) - span);
   endfunction

   function automatic tri_item_type random_triangle();
      tri_item_type t;
      int kind, span, dx, dy, k1, k2;
      kind = $urandom_range(9);
      span = ($urandom_range(3) == 0) ? 2048 : (1 << $urandom_range(11, 2));
      t.ax = rand_coord(span); t.ay = rand_coord(span);
      t.bx = rand_coord(span); t.by = rand_coord(span);
      t.cx = rand_coord(span); t.cy = rand_coord(span);
      t.px = rand_coord(span); t.py = rand_coord(span);
      if (span == 2048) begin
         {t.ax, t.ay, t.bx, t.by} = 48'({$urandom, $urandom});
         {t.cx, t.cy} = 24'($urandom);
         {t.px, t.py} = 24'($urandom);
      end
      case (kind)
         0: begin
            // collinear vertices
            dx = $urandom_range(16) - 8;
            dy = $urandom_range(16) - 8;
            k1 = $urandom_range(40) - 20;
            k2 = $urandom_range(40) - 20;
            t.ax = rand_coord(1000); t.ay = rand_coord(1000);
            t.bx = t.ax + coord_type'(k1 * dx); t.by = t.ay + coord_type'(k1 * dy);
            t.cx = t.ax + coord_type'(k2 * dx); t.cy = t.ay + coord_type'(k2 * dy);
         end
         1: begin
            t.px = t.ax; t.py = t.ay;
         end
         2: begin
            t.px = t.cx; t.py = t.cy;
         end
         3: begin
            // nearly flat triangle, large center
            t.cx = t.bx + coord_type'($urandom_range(2) - 1);
            t.cy = t.by + coord_type'($urandom_range(2) - 1);
            t.bx = t.ax + (t.cx - t.ax) / 2;
            t.by = t.ay + (t.cy - t.ay) / 2 + coord_type'($urandom_range(1));
         end
         4: begin
            // symmetric point on the circle of a right triangle
            t.cx = t.bx; t.cy = t.ay;
            t.px = t.ax; t.py = t.by;
         end
         default: ;
      endcase
      return t;
   endfunction

   function automatic tri_item_type make_tri(int ax, int ay, int bx, int by,
                                             int cx, int cy, int px, int py);
      tri_item_type t;
      t.ax = coord_type'(ax); t.ay = coord_type'(ay);
      t.bx = coord_type'(bx); t.by = coord_type'(by);
      t.cx = coord_type'(cx); t.cy = coord_type'(cy);
      t.px = coord_type'(px); t.py = coord_type'(py);
      return t;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !took) begin
         start <= 1'b1;
      end else if (pending_items.size() > 0 &&
                   ((items_sent >= 250 && items_sent < 400) || $urandom_range(99) >= 8)) begin
         tri_item_type t;
         t = pending_items.pop_front();
         {req_a_x, req_a_y, req_b_x, req_b_y} <= {t.ax, t.ay, t.bx, t.by};
         {req_c_x, req_c_y, req_probe_x, req_probe_y} <= {t.cx, t.cy, t.px, t.py};
         start <= 1'b1;
         items_sent <= items_sent + 1;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      took <= start && !busy && !reset;
      if (!reset && start && !busy) begin
         tri_item_type t;
         t = '{req_a_x, req_a_y, req_b_x, req_b_y, req_c_x, req_c_y,
               req_probe_x, req_probe_y};
         expected_circles.push_back(circumcircle_of(t));
      end
      if (!reset && rsp_valid) begin
         if (expected_circles.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d", $time, rsp_center_x, rsp_center_y);
            errors <= errors + 1;
         end else begin
            circle_res_type x;
            x = expected_circles.pop_front();
            if (rsp_center_x !== x.center_x) begin
               $display("%0t: center_x expected %0d actual %0d", $time, x.center_x,
                        rsp_center_x);
               errors <= errors + 1;
            end
            if (rsp_center_y !== x.center_y) begin
               $display("%0t: center_y expected %0d actual %0d", $time, x.center_y,
                        rsp_center_y);
               errors <= errors + 1;
            end
            if (rsp_inside_res !== x.in_circle) begin
               $display("%0t: inside_res expected %0b actual %0b", $time, x.in_circle,
                        rsp_inside_res);
               errors <= errors + 1;
            end
            if (rsp_degenerate !== x.degen) begin
               $display("%0t: degenerate expected %0b actual %0b", $time, x.degen,
                        rsp_degenerate);
               errors <= errors + 1;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("circumcircle_point_test regression: fail");
      $finish;
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      took = 1'b0;
      items_sent = 0;
      errors = 0;
      {req_a_x, req_a_y, req_b_x, req_b_y, req_c_x, req_c_y, req_probe_x, req_probe_y} = '0;
      pending_items.push_back(make_tri(0, 0, 4, 0, 0, 4, 1, 1));
      pending_items.push_back(make_tri(0, 0, 4, 0, 0, 4, 4, 4));
      pending_items.push_back(make_tri(0, 0, 4, 0, 0, 4, 5, 5));
      pending_items.push_back(make_tri(0, 0, 0, 4, 4, 0, -3, -3));
      pending_items.push_back(make_tri(-2048, -2048, 2047, -2048, -2048, 2047, 2047, 2047));
      pending_items.push_back(make_tri(2047, 2047, -2048, 2047, 2047, -2048, -2048, -2048));
      pending_items.push_back(make_tri(-2048, -2048, 2047, 2047, 0, 0, 5, 5));
      pending_items.push_back(make_tri(1, 1, 1, 1, 1, 1, 0, 0));
      pending_items.push_back(make_tri(5, 7, 5, 7, 100, 3, 5, 7));
      pending_items.push_back(make_tri(-2048, -2048, 2047, 2047, 2047, 2046, 0, 0));
      pending_items.push_back(make_tri(-2048, 2047, 2047, -2048, 2046, -2048, -2048, 2047));
      pending_items.push_back(make_tri(0, 0, 1, 0, 0, 1, 2047, -2048));
      pending_items.push_back(make_tri(0, 0, 2047, 0, 2047, 1, -2048, -2048));
      pending_items.push_back(make_tri(-1, -1, 1, -1, 0, 2, 0, 0));
      pending_items.push_back(make_tri(3, 0, -3, 0, 0, 3, 0, -3));
      pending_items.push_back(make_tri(3, 0, 0, 3, -3, 0, 0, -4));
      pending_items.push_back(make_tri(-2048, 0, 2047, 0, 0, -1, 0, 0));
      pending_items.push_back(make_tri(0, -2048, 0, 2047, 1, 0, -1, -1));
      repeat (540) pending_items.push_back(random_triangle());
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_items.size() == 0);
      @(posedge clock);
      while (start || expected_circles.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0)
         $display("circumcircle_point_test regression: pass");
      else
         $display("circumcircle_point_test regression: fail");
      $finish;
   end

endmodule
